// ===== rtl/lossless_image_predictor_top_defines.svh =====
// Assertion macros used by the predictor top module.
`ifndef LOSSLESS_IMAGE_PREDICTOR_TOP_DEFINES_SVH
`define LOSSLESS_IMAGE_PREDICTOR_TOP_DEFINES_SVH

// Checked only outside reset.
`define LIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define LIP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/lip_pkg.sv =====
package lip_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int HEIGHT_LIMIT = 8192;
  localparam int ADDR_W       = $clog2(MAX_WIDTH);

  localparam int PIX_W    = 8;
  localparam int RES_W    = 10;
  localparam int MODE_W   = 4;
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 14;
  localparam int ROW_W    = 13;
  localparam int CFG_W    = 14;
  localparam int CMP_W    = (WIDTH_W > ADDR_W + 1) ? WIDTH_W + 1 : ADDR_W + 2;
  localparam int HCMP_W   = HEIGHT_W + 1;

  typedef enum logic [1:0] {
    CFG_MODE   = 2'd0,
    CFG_DIR    = 2'd1,
    CFG_WIDTH  = 2'd2,
    CFG_HEIGHT = 2'd3
  } cfg_idx_e;

  localparam logic [MODE_W-1:0] MODE_LEFT   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_UP     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_UPLEFT = 4'd3;
  localparam logic [MODE_W-1:0] MODE_PLANAR = 4'd4;
  localparam logic [MODE_W-1:0] MODE_AVG_A  = 4'd5;
  localparam logic [MODE_W-1:0] MODE_AVG_B  = 4'd6;
  localparam logic [MODE_W-1:0] MODE_AVG_AB = 4'd7;
  localparam logic [MODE_W-1:0] MODE_MED    = 4'd8;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_LEFT;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 13'd1920;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 14'd1080;

  // Position of one item in the frame, carried along with it.
  typedef struct packed {
    logic [ADDR_W-1:0] col;
    logic              col_nz;
    logic              row_nz;
    logic              eol;
    logic              eof;
  } pos_t;

endpackage

// ===== rtl/lip_row_mem.sv =====
module lip_row_mem (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      we_i,
  input  logic [lip_pkg::ADDR_W-1:0] waddr_i,
  input  logic [lip_pkg::PIX_W-1:0]  wdata_i,
  input  logic                      re_i,
  input  logic [lip_pkg::ADDR_W-1:0] raddr_i,
  output logic [lip_pkg::PIX_W-1:0]  rdata_o
);

  logic [lip_pkg::PIX_W-1:0] mem_q [lip_pkg::MAX_WIDTH];
  logic [lip_pkg::PIX_W-1:0] rd_raw_q;
  logic [lip_pkg::PIX_W-1:0] fwd_data_q;
  logic                      fwd_hit_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_raw_q   <= mem_q[raddr_i];
      fwd_data_q <= wdata_i;
    end
  end

  // Same-edge write and read of one entry: the array returns the old value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_hit_q <= 1'b0;
    end else if (re_i) begin
      fwd_hit_q <= we_i && (waddr_i == raddr_i);
    end
  end

  assign rdata_o = fwd_hit_q ? fwd_data_q : rd_raw_q;

endmodule

// ===== rtl/lip_pred.sv =====
module lip_pred (
  input  logic [lip_pkg::MODE_W-1:0]       mode_i,
  input  logic                             dir_i,
  input  lip_pkg::pos_t                    pos_i,
  input  logic [lip_pkg::PIX_W-1:0]        left_i,
  input  logic [lip_pkg::PIX_W-1:0]        above_i,
  input  logic [lip_pkg::PIX_W-1:0]        upleft_i,
  input  logic [lip_pkg::PIX_W-1:0]        pixel_i,
  input  logic signed [lip_pkg::RES_W-1:0] residual_i,
  output logic signed [lip_pkg::RES_W-1:0] residual_o,
  output logic [lip_pkg::PIX_W-1:0]        pixel_o
);

  logic signed [10:0] a, b, c;
  logic signed [10:0] planar;
  logic signed [10:0] bc_diff, ac_diff;
  logic signed [10:0] bc_half, ac_half;
  logic signed [10:0] ab_half;
  logic signed [10:0] mx, mn;
  logic signed [10:0] pred;
  logic               valid;
  logic signed [10:0] enc_res;
  logic signed [10:0] dec_sum;

  // Neighbors outside the frame read as zero.
  assign a = pos_i.col_nz ? $signed({3'b000, left_i}) : 11'sd0;
  assign b = pos_i.row_nz ? $signed({3'b000, above_i}) : 11'sd0;
  assign c = (pos_i.row_nz && pos_i.col_nz) ? $signed({3'b000, upleft_i}) : 11'sd0;

  assign planar  = a + b - c;
  assign bc_diff = b - c;
  assign ac_diff = a - c;
  // Halve toward zero: bias negative values by one before the shift.
  assign bc_half = (bc_diff + $signed({10'd0, bc_diff[10]})) >>> 1;
  assign ac_half = (ac_diff + $signed({10'd0, ac_diff[10]})) >>> 1;
  assign ab_half = (a + b) >>> 1;
  assign mx      = (a > b) ? a : b;
  assign mn      = (a > b) ? b : a;

  always_comb begin
    valid = 1'b1;
    case (mode_i)
      lip_pkg::MODE_LEFT:   pred = a;
      lip_pkg::MODE_UP:     pred = b;
      lip_pkg::MODE_UPLEFT: pred = c;
      lip_pkg::MODE_PLANAR: pred = planar;
      lip_pkg::MODE_AVG_A:  pred = a + bc_half;
      lip_pkg::MODE_AVG_B:  pred = b + ac_half;
      lip_pkg::MODE_AVG_AB: pred = ab_half;
      lip_pkg::MODE_MED: begin
        if (c >= mx) begin
          pred = mn;
        end else if (c <= mn) begin
          pred = mx;
        end else begin
          pred = planar;
        end
      end
      default: begin
        valid = 1'b0;
        pred  = 11'sd0;
      end
    endcase
  end

  assign enc_res = $signed({3'b000, pixel_i}) - pred;
  assign dec_sum = 11'(residual_i) + pred;

  always_comb begin
    if (dir_i == lip_pkg::DIR_DECODE) begin
      residual_o = residual_i;
      pixel_o    = valid ? dec_sum[lip_pkg::PIX_W-1:0] : '0;
    end else begin
      residual_o = valid ? enc_res[lip_pkg::RES_W-1:0] : '0;
      pixel_o    = pixel_i;
    end
  end

endmodule

// ===== rtl/lossless_image_predictor_top.sv =====
// Channel   Direction  Handshake                  Payload
// in        sink       in_valid_i / in_ready_o    pixel_in_i, residual_in_i
// out       source     out_valid_o / out_ready_i  residual_out_o, pixel_out_o,
//                                                 end_of_line_o, end_of_frame_o
// cfg       sink       cfg_we_i                   cfg_index_i, cfg_data_i
//
// One item per cycle unless the output stalls. The accepting edge reads the row store;
// the edge that advances the read stage predicts from it, writes the row store back and
// loads the output register. Same-column write and read is forwarded.
// Reset clears counters and neighbor registers and loads the default configuration; the
// row store is not cleared and needs no clearing pass.
// A stalled output holds the prediction stage; input stays open while that stage is free.

`include "lossless_image_predictor_top_defines.svh"

module lossless_image_predictor_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  lip_pkg::cfg_idx_e                 cfg_index_i,
  input  logic [lip_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [lip_pkg::PIX_W-1:0]         pixel_in_i,
  input  logic signed [lip_pkg::RES_W-1:0]  residual_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [lip_pkg::RES_W-1:0]  residual_out_o,
  output logic [lip_pkg::PIX_W-1:0]         pixel_out_o,
  output logic                              end_of_line_o,
  output logic                              end_of_frame_o
);

  localparam int CW = lip_pkg::CMP_W;
  localparam int HW = lip_pkg::HCMP_W;

  logic [lip_pkg::MODE_W-1:0]   mode_q;
  logic                         dir_q;
  logic [lip_pkg::WIDTH_W-1:0]  width_q;
  logic [lip_pkg::HEIGHT_W-1:0] height_q;

  logic [lip_pkg::ADDR_W-1:0] col_q, col_d;
  logic [lip_pkg::ROW_W-1:0]  row_q, row_d;
  logic [CW-1:0]              w_eff;
  logic [HW-1:0]              h_eff;
  lip_pkg::pos_t              pos_d;

  logic                              s1_valid_q;
  lip_pkg::pos_t                     s1_pos_q;
  logic [lip_pkg::PIX_W-1:0]         s1_pix_q;
  logic signed [lip_pkg::RES_W-1:0]  s1_res_q;
  logic                              s1_adv;
  logic                              accept;

  logic [lip_pkg::PIX_W-1:0]         left_q, upleft_q;
  logic [lip_pkg::PIX_W-1:0]         above;
  logic signed [lip_pkg::RES_W-1:0]  res_new;
  logic [lip_pkg::PIX_W-1:0]         pix_new;

  logic                              out_valid_q;
  logic signed [lip_pkg::RES_W-1:0]  out_res_q;
  logic [lip_pkg::PIX_W-1:0]         out_pix_q;
  logic                              out_eol_q, out_eof_q;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= lip_pkg::MODE_RESET;
      dir_q    <= lip_pkg::DIR_ENCODE;
      width_q  <= lip_pkg::WIDTH_RESET;
      height_q <= lip_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lip_pkg::CFG_MODE:   mode_q   <= cfg_data_i[lip_pkg::MODE_W-1:0];
        lip_pkg::CFG_DIR:    dir_q    <= cfg_data_i[0];
        lip_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[lip_pkg::WIDTH_W-1:0];
        lip_pkg::CFG_HEIGHT: height_q <= cfg_data_i[lip_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width and height to their usable range.
  always_comb begin
    if (width_q == '0) begin
      w_eff = CW'(1);
    end else if (CW'(width_q) > CW'(lip_pkg::MAX_WIDTH)) begin
      w_eff = CW'(lip_pkg::MAX_WIDTH);
    end else begin
      w_eff = CW'(width_q);
    end
    if (height_q == '0) begin
      h_eff = HW'(1);
    end else if (HW'(height_q) > HW'(lip_pkg::HEIGHT_LIMIT)) begin
      h_eff = HW'(lip_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = HW'(height_q);
    end
  end

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  // Position of the item at the input and the counters after it.
  always_comb begin
    pos_d.col    = col_q;
    pos_d.col_nz = (col_q != '0);
    pos_d.row_nz = (row_q != '0);
    pos_d.eol    = (CW'(col_q) + CW'(1)) >= w_eff;
    pos_d.eof    = pos_d.eol && ((HW'(row_q) + HW'(1)) >= h_eff);
    col_d        = col_q;
    row_d        = row_q;
    if (accept) begin
      if (pos_d.eol) begin
        col_d = '0;
        row_d = pos_d.eof ? '0 : row_q + lip_pkg::ROW_W'(1);
      end else begin
        col_d = col_q + lip_pkg::ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Read stage: the row store read runs alongside.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pos_q <= pos_d;
      s1_pix_q <= pixel_in_i;
      s1_res_q <= residual_in_i;
    end
  end

  lip_row_mem u_row_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s1_adv),
    .waddr_i (s1_pos_q.col),
    .wdata_i (pix_new),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (above)
  );

  lip_pred u_pred (
    .mode_i     (mode_q),
    .dir_i      (dir_q),
    .pos_i      (s1_pos_q),
    .left_i     (left_q),
    .above_i    (above),
    .upleft_i   (upleft_q),
    .pixel_i    (s1_pix_q),
    .residual_i (s1_res_q),
    .residual_o (res_new),
    .pixel_o    (pix_new)
  );

  // Neighbor registers advance with each finished item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      upleft_q <= '0;
    end else if (s1_adv) begin
      left_q   <= pix_new;
      upleft_q <= above;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_res_q <= res_new;
      out_pix_q <= pix_new;
      out_eol_q <= s1_pos_q.eol;
      out_eof_q <= s1_pos_q.eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign residual_out_o = out_res_q;
  assign pixel_out_o    = out_pix_q;
  assign end_of_line_o  = out_eol_q;
  assign end_of_frame_o = out_eof_q;

  `LIP_ASSERT(a_s1_hold, s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_pos_q), "read stage item lost while stalled")
  `LIP_ASSERT(a_eof_eol, s1_valid_q |-> !s1_pos_q.eof || s1_pos_q.eol, "end of frame without end of line")
  `LIP_ASSERT(a_frame_wrap, accept && pos_d.eof |=> col_q == '0 && row_q == '0, "counters did not wrap at end of frame")
  `LIP_ASSERT(a_col_move, !accept |=> $stable(col_q) && $stable(row_q), "position moved without an item")
  `LIP_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !s1_valid_q && !out_valid_q, "pipeline not empty in reset")

endmodule

// ===== tb/lossless_image_predictor_top_tb.sv =====
module lossless_image_predictor_top_tb;

  localparam logic [lip_pkg::MODE_W-1:0] MODE_NONE     = 4'd0;
  localparam logic [lip_pkg::MODE_W-1:0] MODE_TOP_CODE = 4'd15;
  localparam int unsigned                TAIL_CYCLES   = 8;
  localparam int unsigned                RANDOM_ITEMS  = 940;
  localparam int unsigned                WIDE_ITEMS    = 64;

  typedef struct packed {
    logic signed [lip_pkg::RES_W-1:0] residual;
    logic [lip_pkg::PIX_W-1:0]        pixel;
    logic                             eol;
    logic                             eof;
  } plane_out_t;

  typedef enum {RX_OPEN, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_style_e;
  typedef enum {CONTENT_NOISE, CONTENT_SMOOTH, CONTENT_EXTREME} content_e;

  logic                             clk_i         = 1'b0;
  logic                             rst_ni        = 1'b1;
  logic                             cfg_we_i      = 1'b0;
  lip_pkg::cfg_idx_e                cfg_index_i   = lip_pkg::CFG_MODE;
  logic [lip_pkg::CFG_W-1:0]        cfg_data_i    = '0;
  logic                             in_valid_i    = 1'b0;
  logic                             in_ready_o;
  logic [lip_pkg::PIX_W-1:0]        pixel_in_i    = '0;
  logic signed [lip_pkg::RES_W-1:0] residual_in_i = '0;
  logic                             out_valid_o;
  logic                             out_ready_i   = 1'b0;
  logic signed [lip_pkg::RES_W-1:0] residual_out_o;
  logic [lip_pkg::PIX_W-1:0]        pixel_out_o;
  logic                             end_of_line_o;
  logic                             end_of_frame_o;

  // Predictor state, mirrored from the block's behavior
  logic [lip_pkg::MODE_W-1:0]   mdl_mode;
  logic                         mdl_dir;
  logic [lip_pkg::WIDTH_W-1:0]  mdl_width;
  logic [lip_pkg::HEIGHT_W-1:0] mdl_height;
  logic [lip_pkg::PIX_W-1:0]    line_mem [lip_pkg::MAX_WIDTH];
  logic [lip_pkg::PIX_W-1:0]    left_pix;
  logic [lip_pkg::PIX_W-1:0]    upleft_pix;
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  int unsigned                  cols_written;

  plane_out_t  predicted_samples [$];
  int unsigned mismatch_count = 0;
  int unsigned burst_left     = 0;
  logic [lip_pkg::PIX_W-1:0] trend_pix = '0;

  rx_style_e   rx_style   = RX_OPEN;
  int unsigned rx_left    = 0;

  lossless_image_predictor_top u_top (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic int unsigned clamp_width(input logic [lip_pkg::WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (w > lip_pkg::MAX_WIDTH) return lip_pkg::MAX_WIDTH;
    return 32'(w);
  endfunction

  function automatic int unsigned clamp_height(input logic [lip_pkg::HEIGHT_W-1:0] h);
    if (h == 0) return 1;
    if (h > lip_pkg::HEIGHT_LIMIT) return lip_pkg::HEIGHT_LIMIT;
    return 32'(h);
  endfunction

  function automatic bit mode_known(input logic [lip_pkg::MODE_W-1:0] mode);
    return (mode >= lip_pkg::MODE_LEFT) && (mode <= lip_pkg::MODE_MED);
  endfunction

  function automatic int predict_value(input logic [lip_pkg::MODE_W-1:0] mode, input int a,
                                       input int b, input int c);
    int lo;
    int hi;
    lo = (a < b) ? a : b;
    hi = (a > b) ? a : b;
    case (mode)
      lip_pkg::MODE_LEFT:   return a;
      lip_pkg::MODE_UP:     return b;
      lip_pkg::MODE_UPLEFT: return c;
      lip_pkg::MODE_PLANAR: return a + b - c;
      lip_pkg::MODE_AVG_A:  return a + (b - c) / 2;
      lip_pkg::MODE_AVG_B:  return b + (a - c) / 2;
      lip_pkg::MODE_AVG_AB: return (a + b) / 2;
      lip_pkg::MODE_MED: begin
        if (c >= hi) return lo;
        if (c <= lo) return hi;
        return a + b - c;
      end
      default:              return 0;
    endcase
  endfunction

  function automatic logic [lip_pkg::PIX_W-1:0] next_pixel(input content_e style);
    logic [lip_pkg::PIX_W-1:0] v;
    case (style)
      CONTENT_SMOOTH: begin
        v = lip_pkg::PIX_W'($urandom_range(6, 0));
        trend_pix = lip_pkg::PIX_W'(trend_pix + v - 3);
        v = trend_pix;
      end
      CONTENT_EXTREME: v = $urandom_range(1, 0) ? 8'hFF : 8'h00;
      default:         v = lip_pkg::PIX_W'($urandom_range(255, 0));
    endcase
    return v;
  endfunction

  function automatic logic signed [lip_pkg::RES_W-1:0] next_residual(input content_e style);
    int r;
    case (style)
      CONTENT_SMOOTH: begin
        r = $urandom_range(12, 0);
        r = r - 6;
      end
      CONTENT_EXTREME: begin
        case ($urandom_range(3, 0))
          0:       r = -510;
          1:       r = 255;
          2:       r = 0;
          default: r = -1;
        endcase
      end
      default: begin
        r = $urandom_range(765, 0);
        r = r - 510;
      end
    endcase
    return r[lip_pkg::RES_W-1:0];
  endfunction

  task automatic reset_predictor();
    mdl_mode     = lip_pkg::MODE_RESET;
    mdl_dir      = lip_pkg::DIR_ENCODE;
    mdl_width    = lip_pkg::WIDTH_RESET;
    mdl_height   = lip_pkg::HEIGHT_RESET;
    left_pix     = '0;
    upleft_pix   = '0;
    col_pos      = 0;
    row_pos      = 0;
    cols_written = 0;
    foreach (line_mem[i]) line_mem[i] = '0;
  endtask

  // Advance the predictor by one accepted item and queue its result.
  task automatic predict_sample(input logic [lip_pkg::PIX_W-1:0] pix_in,
                                input logic signed [lip_pkg::RES_W-1:0] res_in);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    int a;
    int b;
    int c;
    int pred;
    int res;
    int pix;
    logic [lip_pkg::PIX_W-1:0] above;
    plane_out_t outcome;
    w     = clamp_width(mdl_width);
    h     = clamp_height(mdl_height);
    col   = (col_pos >= lip_pkg::MAX_WIDTH) ? lip_pkg::MAX_WIDTH - 1 : col_pos;
    above = line_mem[col];
    b     = (row_pos > 0) ? int'(above) : 0;
    a     = (col > 0) ? int'(left_pix) : 0;
    c     = (row_pos > 0 && col > 0) ? int'(upleft_pix) : 0;
    pred  = predict_value(mdl_mode, a, b, c);
    if (mdl_dir == lip_pkg::DIR_ENCODE) begin
      pix = int'(pix_in);
      res = mode_known(mdl_mode) ? pix - pred : 0;
    end else begin
      res = int'(res_in);
      pix = mode_known(mdl_mode) ? ((res + pred) & 255) : 0;
    end
    upleft_pix    = above;
    line_mem[col] = pix[lip_pkg::PIX_W-1:0];
    left_pix      = pix[lip_pkg::PIX_W-1:0];
    if (col + 1 > cols_written) cols_written = col + 1;
    outcome.residual = res[lip_pkg::RES_W-1:0];
    outcome.pixel    = pix[lip_pkg::PIX_W-1:0];
    outcome.eol      = (col_pos + 1 >= w);
    outcome.eof      = outcome.eol && (row_pos + 1 >= h);
    if (outcome.eol) begin
      col_pos = 0;
      row_pos = outcome.eof ? 0 : row_pos + 1;
    end else begin
      col_pos = col_pos + 1;
    end
    predicted_samples.push_back(outcome);
  endtask

  // Enter and leave at a falling edge; valid stays up while the burst lasts.
  task automatic send_item(input logic [lip_pkg::PIX_W-1:0] pix,
                           input logic signed [lip_pkg::RES_W-1:0] res);
    int unsigned gap;
    in_valid_i    = 1'b1;
    pixel_in_i    = pix;
    residual_in_i = res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_sample(pix, res);
    @(negedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      gap = $urandom_range(8, 1);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(9, 0) == 0) ? $urandom_range(300, 100) : $urandom_range(24, 1);
    end
  endtask

  // Drop valid, let every queued result drain, then settle past the pipeline.
  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (predicted_samples.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input lip_pkg::cfg_idx_e idx, input int unsigned value);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value[lip_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    case (idx)
      lip_pkg::CFG_MODE:   mdl_mode   = value[lip_pkg::MODE_W-1:0];
      lip_pkg::CFG_DIR:    mdl_dir    = value[0];
      lip_pkg::CFG_WIDTH:  mdl_width  = value[lip_pkg::WIDTH_W-1:0];
      lip_pkg::CFG_HEIGHT: mdl_height = value[lip_pkg::HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_style = rx_style_e'($urandom_range(3, 0));
      rx_left  = $urandom_range(80, 8);
    end
    rx_left--;
    case (rx_style)
      RX_OPEN:     out_ready_i = 1'b1;
      RX_LIGHT:    out_ready_i = ($urandom_range(3, 0) != 0);
      RX_PERIODIC: out_ready_i = ((rx_left % 5) < 3);
      default:     out_ready_i = ($urandom_range(3, 0) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    plane_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_samples.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected item: residual %0d pixel %0d eol %0b eof %0b",
                   residual_out_o, pixel_out_o, end_of_line_o, end_of_frame_o);
        mismatch_count++;
      end else begin
        want = predicted_samples.pop_front();
        if (residual_out_o !== want.residual || pixel_out_o !== want.pixel ||
            end_of_line_o !== want.eol || end_of_frame_o !== want.eof) begin
          if (mismatch_count < 10)
            $display("mismatch: residual %0d/%0d pixel %0d/%0d eol %0b/%0b eof %0b/%0b (exp/got)",
                     want.residual, residual_out_o, want.pixel, pixel_out_o,
                     want.eol, end_of_line_o, want.eof, end_of_frame_o);
          mismatch_count++;
        end
      end
    end
  end

  // Reset configuration, first row only.
  task automatic test_reset_state();
    send_item(8'd0, next_residual(CONTENT_NOISE));
    send_item(8'd255, next_residual(CONTENT_NOISE));
    send_item(8'd128, next_residual(CONTENT_NOISE));
    send_item(8'd1, next_residual(CONTENT_NOISE));
  endtask

  // Narrowing mid-row ends the row at once; then walk every predictor and two unused codes.
  task automatic test_each_predictor();
    logic [lip_pkg::MODE_W-1:0] modes [10];
    logic [lip_pkg::PIX_W-1:0]  pixels [10];
    modes  = '{lip_pkg::MODE_LEFT, lip_pkg::MODE_UP, lip_pkg::MODE_UPLEFT, lip_pkg::MODE_PLANAR,
               lip_pkg::MODE_AVG_A, lip_pkg::MODE_AVG_B, lip_pkg::MODE_AVG_AB, lip_pkg::MODE_MED,
               MODE_NONE, MODE_TOP_CODE};
    pixels = '{8'd200, 8'd40, 8'd90, 8'd10, 8'd255, 8'd0, 8'd77, 8'd128, 8'd3, 8'd250};
    wait_idle();
    write_reg(lip_pkg::CFG_WIDTH, 3);
    write_reg(lip_pkg::CFG_HEIGHT, 4);
    for (int i = 0; i < 10; i++) begin
      wait_idle();
      write_reg(lip_pkg::CFG_MODE, modes[i]);
      send_item(pixels[i], next_residual(CONTENT_NOISE));
    end
  endtask

  task automatic test_decode();
    wait_idle();
    write_reg(lip_pkg::CFG_DIR, lip_pkg::DIR_DECODE);
    write_reg(lip_pkg::CFG_MODE, lip_pkg::MODE_PLANAR);
    write_reg(lip_pkg::CFG_WIDTH, 2);
    write_reg(lip_pkg::CFG_HEIGHT, 2);
    send_item(next_pixel(CONTENT_NOISE), -10'sd510);
    send_item(next_pixel(CONTENT_NOISE), 10'sd255);
    send_item(next_pixel(CONTENT_NOISE), 10'sd0);
    send_item(next_pixel(CONTENT_NOISE), -10'sd1);
    wait_idle();
    write_reg(lip_pkg::CFG_MODE, MODE_TOP_CODE);
    send_item(next_pixel(CONTENT_NOISE), next_residual(CONTENT_NOISE));
  endtask

  task automatic test_size_extremes();
    wait_idle();
    write_reg(lip_pkg::CFG_DIR, lip_pkg::DIR_ENCODE);
    write_reg(lip_pkg::CFG_MODE, lip_pkg::MODE_MED);
    write_reg(lip_pkg::CFG_WIDTH, 0);
    write_reg(lip_pkg::CFG_HEIGHT, 0);
    repeat (2) send_item(next_pixel(CONTENT_NOISE), next_residual(CONTENT_NOISE));
    wait_idle();
    write_reg(lip_pkg::CFG_WIDTH, 1);
    write_reg(lip_pkg::CFG_HEIGHT, 16383);
    repeat (3) send_item(next_pixel(CONTENT_NOISE), next_residual(CONTENT_NOISE));
    wait_idle();
    write_reg(lip_pkg::CFG_HEIGHT, lip_pkg::HEIGHT_LIMIT);
    send_item(next_pixel(CONTENT_NOISE), next_residual(CONTENT_NOISE));
    // row counter is already past the new height: next item closes the frame
    wait_idle();
    write_reg(lip_pkg::CFG_HEIGHT, 2);
    send_item(next_pixel(CONTENT_NOISE), next_residual(CONTENT_NOISE));
    wait_idle();
    write_reg(lip_pkg::CFG_WIDTH, lip_pkg::MAX_WIDTH);
    write_reg(lip_pkg::CFG_HEIGHT, 1);
    repeat (3) send_item(next_pixel(CONTENT_NOISE), next_residual(CONTENT_NOISE));
    wait_idle();
    write_reg(lip_pkg::CFG_WIDTH, 2);
    send_item(next_pixel(CONTENT_NOISE), next_residual(CONTENT_NOISE));
  endtask

  // Width above the store size acts as the full store: a long run stays inside one row.
  task automatic test_widest_row();
    wait_idle();
    write_reg(lip_pkg::CFG_WIDTH, 8191);
    write_reg(lip_pkg::CFG_HEIGHT, 1);
    write_reg(lip_pkg::CFG_MODE, lip_pkg::MODE_AVG_A);
    write_reg(lip_pkg::CFG_DIR, $urandom_range(1, 0) ? lip_pkg::DIR_DECODE : lip_pkg::DIR_ENCODE);
    repeat (WIDE_ITEMS) send_item(next_pixel(CONTENT_SMOOTH), next_residual(CONTENT_SMOOTH));
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned n;
    int unsigned w;
    int unsigned pick;
    content_e    style;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(1, 0)) begin
        pick = $urandom_range(9, 0);
        if (pick == 0)      write_reg(lip_pkg::CFG_MODE, MODE_NONE);
        else if (pick == 1) write_reg(lip_pkg::CFG_MODE,
                                      $urandom_range(MODE_TOP_CODE, lip_pkg::MODE_MED + 1));
        else                write_reg(lip_pkg::CFG_MODE,
                                      $urandom_range(lip_pkg::MODE_MED, lip_pkg::MODE_LEFT));
      end
      if ($urandom_range(2, 0) == 0)
        write_reg(lip_pkg::CFG_DIR,
                  $urandom_range(1, 0) ? lip_pkg::DIR_DECODE : lip_pkg::DIR_ENCODE);
      if ($urandom_range(2, 0) == 0) begin
        pick = $urandom_range(19, 0);
        if (pick == 0)      w = 0;
        else if (pick == 1) w = $urandom_range(300, 100);
        else                w = $urandom_range(12, 1);
        // never widen past columns that were written while rows above are read
        if (row_pos != 0 && clamp_width(lip_pkg::WIDTH_W'(w)) > cols_written) w = cols_written;
        write_reg(lip_pkg::CFG_WIDTH, w);
      end
      if ($urandom_range(2, 0) == 0)
        write_reg(lip_pkg::CFG_HEIGHT, ($urandom_range(15, 0) == 0) ? 0 : $urandom_range(5, 1));
      style = content_e'($urandom_range(2, 0));
      n = ($urandom_range(4, 0) == 0) ? $urandom_range(3, 1) : $urandom_range(48, 4);
      repeat (n) begin
        send_item(next_pixel(style), next_residual(style));
        sent++;
      end
    end
  endtask

  initial begin
    reset_predictor();
    #1;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_each_predictor();
    test_decode();
    test_size_extremes();
    test_widest_row();
    test_random_frames();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== lossless_image_predictor_top.f =====
+incdir+rtl
rtl/lip_pkg.sv
rtl/lip_row_mem.sv
rtl/lip_pred.sv
rtl/lossless_image_predictor_top.sv
tb/lossless_image_predictor_top_tb.sv
